// ----- hw/rtl/block_min_max_normalizer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// block min-max normalizer assertion macros
// shared concurrent assertion forms, clocked on clk
// ----------------------------------------------------------------------------
`ifndef BLOCK_MIN_MAX_NORMALIZER_UNIT_ASSERT_SVH
`define BLOCK_MIN_MAX_NORMALIZER_UNIT_ASSERT_SVH

// checked outside reset only
`define BMMN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define BMMN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bmmn_pkg.sv -----
// ----------------------------------------------------------------------------
// bmmn_pkg
// types and constants shared by the block min-max normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmmn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 7;   // holds a block length up to 64
  localparam int QUO_W    = 17;  // quotient of num * 2^16 / den, at most 65536
  localparam int REM_W    = 17;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 16'd29491;

  // one finished block, handed from loader to emitter
  typedef struct packed {
    logic                bank;
    logic [CNT_W-1:0]    count;
    logic [SAMPLE_W-1:0] min;
    logic [SAMPLE_W-1:0] den;
    logic                flat;
    logic                dropped;
  } job_t;

  // per-result sideband carried along the divider
  typedef struct packed {
    logic [SAMPLE_W-1:0] den;
    logic                flat;
    logic                dropped;
    logic                last;
  } meta_t;

  typedef struct packed {
    meta_t            meta;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmmn_front.sv -----
// ----------------------------------------------------------------------------
// bmmn_front
// sample loader: stores one block, tracks min, max, count and overflow
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmmn_front #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bmmn_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                         s_tlast,
  input  logic                         queue_full,
  output logic                         job_push,
  output bmmn_pkg::job_t               job,
  output logic                         mem_we,
  output logic [$clog2(DEPTH):0]       mem_waddr,
  output logic [bmmn_pkg::SAMPLE_W-1:0] mem_wdata
);
  import bmmn_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic                       bank;
  logic [FW-1:0]              fill, fill_next;
  logic signed [SAMPLE_W-1:0] run_min, run_min_next;
  logic signed [SAMPLE_W-1:0] run_max, run_max_next;
  logic                       ovf, ovf_next;
  logic signed [SAMPLE_W-1:0] x;
  logic                       accept;
  logic                       has_room;

  assign x        = s_tdata;
  assign s_tready = !queue_full;
  assign accept   = s_tvalid && !queue_full;
  assign has_room = (fill != FW'(DEPTH));

  always_comb begin
    fill_next    = fill;
    run_min_next = run_min;
    run_max_next = run_max;
    ovf_next     = ovf;
    if (has_room) begin
      fill_next = fill + FW'(1);
      if (x < run_min) run_min_next = x;
      if (x > run_max) run_max_next = x;
    end else begin
      ovf_next = 1'b1;
    end
  end

  assign mem_we    = accept && has_room;
  assign mem_waddr = {bank, fill[IW-1:0]};
  assign mem_wdata = s_tdata;

  assign job_push    = accept && s_tlast;
  assign job.bank    = bank;
  assign job.count   = CNT_W'(fill_next);
  assign job.min     = run_min_next;
  assign job.den     = run_max_next - run_min_next;
  assign job.flat    = (run_max_next == run_min_next);
  assign job.dropped = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank    <= 1'b0;
      fill    <= '0;
      run_min <= 16'sh7fff;
      run_max <= -16'sh8000;
      ovf     <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        // block closed: start the next one in the other bank
        bank    <= !bank;
        fill    <= '0;
        run_min <= 16'sh7fff;
        run_max <= -16'sh8000;
        ovf     <= 1'b0;
      end else begin
        fill    <= fill_next;
        run_min <= run_min_next;
        run_max <= run_max_next;
        ovf     <= ovf_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bmmn_job_queue.sv -----
// ----------------------------------------------------------------------------
// bmmn_job_queue
// two-entry queue of finished blocks between loader and emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_min_max_normalizer_unit_assert.svh"

module bmmn_job_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmmn_pkg::job_t push_job,
  input  logic           pop,
  output logic           head_valid,
  output bmmn_pkg::job_t head,
  output logic           full
);
  import bmmn_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `BMMN_ASSERT(a_no_push_full, push |-> !full, "job pushed into full queue")
  `BMMN_ASSERT(a_no_pop_empty, pop |-> head_valid, "job popped from empty queue")
  `BMMN_ASSERT_ALWAYS(a_reset_empty, rst |=> (count == 2'd0), "queue not empty after reset")

endmodule

`default_nettype wire

// ----- hw/rtl/bmmn_back.sv -----
// ----------------------------------------------------------------------------
// bmmn_back
// emitter: sample buffer, pipelined restoring divider and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_min_max_normalizer_unit_assert.svh"

module bmmn_back #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  bmmn_pkg::job_t                head,
  output logic                          job_pop,
  input  logic                          mem_we,
  input  logic [$clog2(DEPTH):0]        mem_waddr,
  input  logic [bmmn_pkg::SAMPLE_W-1:0] mem_wdata,
  input  logic [bmmn_pkg::SAMPLE_W-1:0] threshold,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bmmn_pkg::SAMPLE_W-1:0] m_tdata,
  output logic [2:0]                    m_tuser,
  output logic                          m_tlast
);
  import bmmn_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int AW = IW + 1;

  // one long-division step: subtract den if it fits, shift in the quotient bit
  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t       r;
    logic             ge;
    logic [REM_W-1:0] diff;
    r    = s;
    ge   = (s.rem >= {1'b0, s.meta.den});
    diff = ge ? (s.rem - {1'b0, s.meta.den}) : s.rem;
    r.rem = {diff[REM_W-2:0], 1'b0};
    r.quo = {s.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  logic [SAMPLE_W-1:0] mem [2**AW];

  logic                en;
  logic                issue;
  logic                last_item;
  logic [IW-1:0]       idx;

  logic                rd_valid;
  meta_t               rd_meta;
  logic [SAMPLE_W-1:0] rd_min;
  logic [SAMPLE_W-1:0] rdata;

  logic [DIV_STEPS:0]  vld;
  div_stage_t          div [DIV_STEPS+1];

  logic [QUO_W-1:0]    rounded;
  logic [SAMPLE_W-1:0] norm;
  logic                flat_out;

  // whole pipeline moves together whenever the output slot frees up
  assign en        = !m_tvalid || m_tready;
  assign issue     = en && head_valid;
  assign last_item = ((CNT_W'(idx) + CNT_W'(1)) == head.count);
  assign job_pop   = issue && last_item;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (en)     rdata <= mem[{head.bank, idx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
    end else if (en) begin
      rd_valid <= head_valid;
      if (issue) idx <= last_item ? '0 : idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_meta.den     <= head.den;
      rd_meta.flat    <= head.flat;
      rd_meta.dropped <= head.dropped;
      rd_meta.last    <= last_item;
      rd_min          <= head.min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-1:0], rd_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div[0].meta <= rd_meta;
      div[0].rem  <= {1'b0, rdata - rd_min};  // sample is never below the block min
      div[0].quo  <= '0;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        div[i] <= div_step(div[i-1]);
      end
    end
  end

  // round half up: (floor(2x) + 1) / 2
  assign rounded  = div[DIV_STEPS].quo + QUO_W'(1);
  assign flat_out = div[DIV_STEPS].meta.flat;
  assign norm     = flat_out ? '0 : rounded[QUO_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= norm;
      m_tuser <= {div[DIV_STEPS].meta.dropped, flat_out, (norm > threshold)};
      m_tlast <= div[DIV_STEPS].meta.last;
    end
  end

  `BMMN_ASSERT(a_flat_zero, (m_tvalid && m_tuser[1]) |-> (m_tdata == '0),
               "flat block beat with nonzero value")
  `BMMN_ASSERT(a_norm_range, m_tvalid |-> (m_tdata <= 16'd32768),
               "normalized value above one")
  `BMMN_ASSERT(a_flat_not_above, (m_tvalid && m_tuser[1]) |-> !m_tuser[0],
               "flat block beat flagged above level")

endmodule

`default_nettype wire

// ----- hw/rtl/block_min_max_normalizer_unit.sv -----
// ----------------------------------------------------------------------------
// block_min_max_normalizer_unit
// min-max normalization of blocks of signed 16-bit samples to unsigned Q1.15
// ----------------------------------------------------------------------------
// Samples load at one beat per cycle into one half of a ping-pong buffer
// while the running min and max are tracked; the beat with tlast closes the
// block and queues it for output. The output side then streams one result
// per cycle when not stalled, (x - min) / (max - min) rounded to nearest in
// Q1.15, through a 17-stage pipelined restoring divider. Loading of the next
// block overlaps with output of the previous one; the input stalls only while
// two closed blocks still wait to be emitted. A flat block yields 0 with the
// flat flag, samples past DEPTH are discarded and every result of that block
// is marked dropped. The user must write the threshold register (reset 0.9)
// only while idle; the unit itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module block_min_max_normalizer_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,  // threshold
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,      // sample
  input  logic        s_tlast,      // block_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // normalized
  output logic [2:0]  m_tuser,      // dropped, flat_block, above_level
  output logic        m_tlast       // run_end
);
  import bmmn_pkg::*;

  localparam int AW = $clog2(DEPTH) + 1;

  logic [SAMPLE_W-1:0] threshold;
  logic                queue_full;
  logic                job_push;
  job_t                push_job;
  logic                job_pop;
  logic                head_valid;
  job_t                head;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  bmmn_front #(.DEPTH(DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .queue_full (queue_full),
    .job_push   (job_push),
    .job        (push_job),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  bmmn_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (queue_full)
  );

  bmmn_back #(.DEPTH(DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .job_pop    (job_pop),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .threshold  (threshold),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_block_min_max_normalizer_unit.sv -----
// ----------------------------------------------------------------------------
// tb_block_min_max_normalizer_unit
// self-checking bench for the block min-max normalizer
// ----------------------------------------------------------------------------
// Sample blocks go in on the slave stream and every emitted result is checked
// against a local model that keeps its own buffer, running min and max,
// overflow flag and threshold copy. Short directed blocks cover the sample
// extremes, flat and single-sample blocks, small spans and threshold edges;
// then buffer-full blocks, back-to-back blocks and random blocks follow, with
// random gaps on the input and random stalls on the output. The threshold is
// rewritten only once the unit has drained.
`timescale 1ns / 1ps

module tb_block_min_max_normalizer_unit;

  localparam int DEPTH       = 64;
  localparam int SETTLE      = 40;    // cycles for the divider pipe to empty
  localparam int TOTAL_ITEMS = 350;
  localparam int MAX_PRINTS  = 50;

  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_FLAT, VAL_EDGE} val_mode_e;

  typedef struct {
    logic [15:0] norm;
    logic        above;
    logic        flat;
    logic        dropped;
    logic        last;
  } norm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // model state
  logic signed [15:0] blk_samples [DEPTH];
  int                 blk_fill;
  int                 blk_min;
  int                 blk_max;
  logic               blk_overflow;
  logic [15:0]        thr_level;
  norm_result_t       expected_norm[$];

  int error_count = 0;
  int items_sent  = 0;
  bit src_idle    = 1'b1;
  bit sink_idle   = 1'b1;
  int stall_left  = 0;

  block_min_max_normalizer_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb_block_min_max_normalizer_unit: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic clear_block();
    blk_fill     = 0;
    blk_min      = 32767;
    blk_max      = -32768;
    blk_overflow = 1'b0;
  endtask

  // update the model with one accepted beat, queue results on block end
  task automatic accept_sample(input logic [15:0] x, input logic is_last);
    int           xv;
    int           den;
    longint       num;
    longint       q;
    norm_result_t r;
    xv = int'($signed(x));
    if (blk_fill < DEPTH) begin
      blk_samples[blk_fill] = x;
      blk_fill++;
      if (xv < blk_min) blk_min = xv;
      if (xv > blk_max) blk_max = xv;
    end else begin
      blk_overflow = 1'b1;
    end
    if (is_last) begin
      den = blk_max - blk_min;
      for (int k = 0; k < blk_fill; k++) begin
        q = 0;
        if (den != 0) begin
          num = longint'(blk_samples[k]) - blk_min;
          q   = (num * 65536 + den) / (2 * longint'(den));
        end
        r.norm    = q[15:0];
        r.above   = (q > longint'(thr_level));
        r.flat    = (den == 0);
        r.dropped = blk_overflow;
        r.last    = (k == blk_fill - 1);
        expected_norm.push_back(r);
      end
      clear_block();
    end
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // output side: random stalls, driven at the falling edge
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (sink_idle && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end
    end
    m_tready = rdy;
  end

  // result checker
  always @(posedge clk) begin
    norm_result_t e;
    string        bad;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_norm.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data %0d user %b last %b",
                                  m_tdata, m_tuser, m_tlast));
      end else begin
        e   = expected_norm.pop_front();
        bad = "";
        if (m_tdata !== e.norm)
          bad = {bad, $sformatf(" normalized %0d/%0d", m_tdata, e.norm)};
        if (m_tuser[0] !== e.above)
          bad = {bad, $sformatf(" above_level %b/%b", m_tuser[0], e.above)};
        if (m_tuser[1] !== e.flat)
          bad = {bad, $sformatf(" flat_block %b/%b", m_tuser[1], e.flat)};
        if (m_tuser[2] !== e.dropped)
          bad = {bad, $sformatf(" dropped %b/%b", m_tuser[2], e.dropped)};
        if (m_tlast !== e.last)
          bad = {bad, $sformatf(" run_end %b/%b", m_tlast, e.last)};
        if (bad != "") report_mismatch({"got/exp:", bad});
      end
    end
  end

  task automatic send_sample(input logic [15:0] x, input logic is_last);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = x;
    s_tlast  = is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accept_sample(x, is_last);
    items_sent++;
  endtask

  // drop valid, let every expected result out and the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_norm.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    thr_level   = v;
  endtask

  task automatic send_list(input logic [15:0] vals[$]);
    foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_block(input int len, input val_mode_e mode);
    int          span;
    int          base;
    logic [15:0] v;
    span = $urandom_range(1, 300);
    base = $urandom_range(0, 65535 - span) - 32768;
    for (int i = 0; i < len; i++) begin
      case (mode)
        VAL_WIDE:   v = 16'($urandom);
        VAL_NARROW: v = 16'(base + $urandom_range(0, span));
        VAL_FLAT:   v = 16'(base);
        default: begin
          case ($urandom_range(0, 4))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'h0000;
            3:       v = 16'hffff;
            default: v = 16'($urandom);
          endcase
        end
      endcase
      send_sample(v, i == len - 1);
    end
  endtask

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hffff;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic test_default_threshold();
    send_list('{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001});
  endtask

  task automatic test_flat_blocks();
    send_list('{16'd100, 16'd100, 16'd100});
    send_list('{16'hfffb});  // single sample is flat too
  endtask

  task automatic test_small_spans();
    send_list('{16'd0, 16'd1, 16'd2, 16'd3});
    send_list('{16'hffff, 16'd0, 16'd1});
  endtask

  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    send_list('{16'h0005, 16'h0006});
    write_threshold(16'd32768);
    send_list('{16'h8000, 16'h7fff});
    write_threshold(16'd32767);
    send_list('{16'h8000, 16'h7fff});
    write_threshold(16'hffff);
    send_list('{16'd5, 16'd9, 16'd7});
    write_threshold(16'd16384);
  endtask

  task automatic test_buffer_limits();
    logic [15:0] v;
    // exactly full, then full with the end beat itself discarded
    send_block(DEPTH, VAL_WIDE);
    v = 16'($urandom);
    for (int i = 0; i < DEPTH; i++) send_sample(v, 1'b0);
    send_sample(~v, 1'b1);   // discarded, so the block stays flat
    send_block(DEPTH + 3, VAL_NARROW);
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    for (int b = 0; b < 8; b++) send_block($urandom_range(1, 6), VAL_WIDE);
    sink_idle = 1'b0;
    for (int b = 0; b < 4; b++) send_block($urandom_range(2, 5), VAL_NARROW);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_random_blocks();
    int        blocks;
    int        len;
    int        r;
    val_mode_e mode;
    blocks = 0;
    while (items_sent < TOTAL_ITEMS) begin
      if (blocks % 7 == 6) write_threshold(pick_threshold());
      else if (blocks % 5 == 4) wait_idle();
      r = $urandom_range(0, 99);
      if (r < 75) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 40);
      else len = $urandom_range(DEPTH - 1, DEPTH + 4);
      r = $urandom_range(0, 9);
      mode = (r < 4) ? VAL_WIDE : (r < 7) ? VAL_NARROW : (r < 8) ? VAL_FLAT : VAL_EDGE;
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      send_block(len, mode);
      blocks++;
    end
  endtask

  initial begin
    thr_level = 16'd29491;
    clear_block();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_threshold();
    test_flat_blocks();
    test_small_spans();
    test_threshold_extremes();
    test_buffer_limits();
    test_back_to_back();
    test_random_blocks();
    wait_idle();
    if (error_count == 0) begin
      $display("tb_block_min_max_normalizer_unit: PASS");
    end else begin
      $display("tb_block_min_max_normalizer_unit: FAIL");
    end
    $finish;
  end

endmodule

// ----- block_min_max_normalizer_unit.f -----
+incdir+hw/rtl
hw/rtl/bmmn_pkg.sv
hw/rtl/bmmn_front.sv
hw/rtl/bmmn_job_queue.sv
hw/rtl/bmmn_back.sv
hw/rtl/block_min_max_normalizer_unit.sv
tb/sv/tb_block_min_max_normalizer_unit.sv
